@@ hw/rtl/resp_stream_parser_assert.svh @@
// Assertion macros for the parser RTL.
`ifndef RESP_STREAM_PARSER_ASSERT_SVH
`define RESP_STREAM_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define RSP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define RSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/rsp_pkg.sv @@
`timescale 1ns / 1ps
package rsp_pkg;

    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef logic [3:0] t_cls;
    localparam t_cls CL_DIGIT  = 4'd0;
    localparam t_cls CL_CR     = 4'd1;
    localparam t_cls CL_LF     = 4'd2;
    localparam t_cls CL_PLUS   = 4'd3;
    localparam t_cls CL_MINUS  = 4'd4;
    localparam t_cls CL_COLON  = 4'd5;
    localparam t_cls CL_DOLLAR = 4'd6;
    localparam t_cls CL_STAR   = 4'd7;
    localparam t_cls CL_OTHER  = 4'd8;

    typedef struct packed {
        logic [7:0] byte_val;
        t_cls       cls;
    } t_word;

    localparam logic [3:0] PH_TYPE      = 4'd0;
    localparam logic [3:0] PH_NUM_FIRST = 4'd1;
    localparam logic [3:0] PH_NUM       = 4'd2;
    localparam logic [3:0] PH_NUM_LF    = 4'd3;
    localparam logic [3:0] PH_LINE      = 4'd4;
    localparam logic [3:0] PH_LINE_LF   = 4'd5;
    localparam logic [3:0] PH_BULK      = 4'd6;
    localparam logic [3:0] PH_BULK_CR   = 4'd7;
    localparam logic [3:0] PH_BULK_LF   = 4'd8;

    localparam logic [2:0] K_SIMPLE    = 3'd0;
    localparam logic [2:0] K_ERROR     = 3'd1;
    localparam logic [2:0] K_INT       = 3'd2;
    localparam logic [2:0] K_BULK      = 3'd3;
    localparam logic [2:0] K_NULLBULK  = 3'd4;
    localparam logic [2:0] K_ARRAY     = 3'd5;
    localparam logic [2:0] K_NULLARRAY = 3'd6;

    localparam logic [1:0] EV_HEAD = 2'd0;
    localparam logic [1:0] EV_DATA = 2'd1;
    localparam logic [1:0] EV_END  = 2'd2;
    localparam logic [1:0] EV_ERR  = 2'd3;

    localparam logic [2:0] E_NONE = 3'd0;
    localparam logic [2:0] E_TYPE = 3'd1;
    localparam logic [2:0] E_PLUS = 3'd2;
    localparam logic [2:0] E_CRLF = 3'd3;
    localparam logic [2:0] E_NEG  = 3'd4;
    localparam logic [2:0] E_DEEP = 3'd5;
    localparam logic [2:0] E_OVF  = 3'd6;

    localparam logic [34:0] LIM_POS = 35'h07FFFFFFF;
    localparam logic [34:0] LIM_NEG = 35'h080000000;

endpackage

@@ hw/rtl/rsp_if.sv @@
`timescale 1ns / 1ps
interface rsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink (input valid, input byte_in, output ready);
endinterface

interface rsp_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         event_res;
    logic [2:0]         kind;
    logic signed [31:0] value;
    logic [7:0]         data_byte;
    logic [3:0]         depth;
    logic               message_done;
    logic [2:0]         error_code;

    modport source (output valid, output event_res, output kind, output value,
                    output data_byte, output depth, output message_done,
                    output error_code, input ready);
    modport sink (input valid, input event_res, input kind, input value,
                  input data_byte, input depth, input message_done,
                  input error_code, output ready);
endinterface

@@ hw/rtl/rsp_front.sv @@
`timescale 1ns / 1ps
module rsp_front
    import rsp_pkg::*;
(
    rsp_in_if.sink i_in,
    input  logic   i_full,
    output logic   o_push,
    output t_word  o_word
);

    t_cls cls;

    always_comb begin
        case (i_in.byte_in)
            CH_CR:     cls = CL_CR;
            CH_LF:     cls = CL_LF;
            CH_PLUS:   cls = CL_PLUS;
            CH_MINUS:  cls = CL_MINUS;
            CH_COLON:  cls = CL_COLON;
            CH_DOLLAR: cls = CL_DOLLAR;
            CH_STAR:   cls = CL_STAR;
            default: begin
                if (i_in.byte_in >= CH_ZERO && i_in.byte_in <= CH_NINE) begin
                    cls = CL_DIGIT;
                end else begin
                    cls = CL_OTHER;
                end
            end
        endcase
    end

    assign i_in.ready      = !i_full;
    assign o_push          = i_in.valid && !i_full;
    assign o_word.byte_val = i_in.byte_in;
    assign o_word.cls      = cls;

endmodule

@@ hw/rtl/rsp_fifo.sv @@
`timescale 1ns / 1ps
module rsp_fifo #(
    parameter int W     = 12,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic         o_full,
    output logic         o_empty,
    output logic [W-1:0] o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    // Depth is a power of two, so the pointers wrap on their own.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + AW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

@@ hw/rtl/rsp_back.sv @@
`timescale 1ns / 1ps
`include "resp_stream_parser_assert.svh"
module rsp_back
    import rsp_pkg::*;
#(
    parameter int MAX_DEPTH = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_word i_word,
    output logic o_pop,
    rsp_out_if.source o_out
);

    localparam int LW = $clog2(MAX_DEPTH + 1);
    localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    logic [3:0]         r_phase, n_phase;
    logic [2:0]         r_kind, n_kind;
    logic [31:0]        r_acc, n_acc;
    logic               r_neg, n_neg;
    logic [30:0]        r_bulk, n_bulk;
    logic [LW-1:0]      r_lvl, n_lvl;
    logic [30:0]        r_stack [MAX_DEPTH];
    logic [MAX_DEPTH-1:0] r_one, n_one;

    logic               r_ovalid;
    logic [1:0]         r_ev;
    logic [2:0]         r_okind;
    logic [31:0]        r_val;
    logic [7:0]         r_data;
    logic [3:0]         r_depth;
    logic               r_done;
    logic [2:0]         r_err;

    logic        take;
    logic        has_res;
    logic [1:0]  res_ev;
    logic [2:0]  res_kind;
    logic [31:0] res_val;
    logic [7:0]  res_data;
    logic        res_done;
    logic [2:0]  res_err;

    logic        st_we;
    logic [IW-1:0] st_addr;
    logic [30:0] st_wdata;

    // Completion search: the deepest open array whose count is not one
    // survives the pop cascade; everything above it closes.
    logic          c_found;
    logic [IW-1:0] c_idx;
    logic [30:0]   c_cnt;

    logic [3:0]  digit;
    logic [34:0] n_num;
    logic [31:0] mag;
    logic [7:0]  b;
    t_cls        cls;
    logic [3:0]  eff_phase;

    assign take  = i_valid && (!r_ovalid || o_out.ready);
    assign o_pop = take;
    assign b     = i_word.byte_val;
    assign cls   = i_word.cls;
    assign digit = 4'(b - CH_ZERO);
    assign n_num = ({3'b0, r_acc} << 3) + ({3'b0, r_acc} << 1) + 35'(digit);
    assign mag   = r_acc;

    always_comb begin
        c_found = 1'b0;
        c_idx   = '0;
        for (int i = 0; i < MAX_DEPTH; i++) begin
            if (LW'(i) < r_lvl && !r_one[i]) begin
                c_found = 1'b1;
                c_idx   = IW'(i);
            end
        end
        c_cnt = r_stack[c_idx];
    end

    always_comb begin
        n_phase  = r_phase;
        n_kind   = r_kind;
        n_acc    = r_acc;
        n_neg    = r_neg;
        n_bulk   = r_bulk;
        n_lvl    = r_lvl;
        n_one    = r_one;
        st_we    = 1'b0;
        st_addr  = c_idx;
        st_wdata = c_cnt - 31'd1;
        has_res  = 1'b0;
        res_ev   = EV_HEAD;
        res_kind = r_kind;
        res_val  = '0;
        res_data = '0;
        res_done = 1'b0;
        res_err  = E_NONE;
        eff_phase = r_phase;

        if (r_phase == PH_NUM_FIRST) begin
            eff_phase = PH_NUM;
            n_phase   = PH_NUM;
            if (cls == CL_PLUS || cls == CL_MINUS) begin
                eff_phase = PH_TYPE + 4'd15;
                if (cls == CL_PLUS && r_kind != K_INT) begin
                    has_res = 1'b1;
                    res_err = E_PLUS;
                end else begin
                    n_neg = (cls == CL_MINUS);
                end
            end
        end

        case (eff_phase)
            PH_TYPE: begin
                n_acc = '0;
                n_neg = 1'b0;
                if (cls == CL_PLUS || cls == CL_MINUS) begin
                    n_kind   = (cls == CL_PLUS) ? K_SIMPLE : K_ERROR;
                    n_phase  = PH_LINE;
                    has_res  = 1'b1;
                    res_kind = n_kind;
                end else if (cls == CL_COLON || cls == CL_DOLLAR || cls == CL_STAR) begin
                    n_kind  = (cls == CL_COLON) ? K_INT :
                              (cls == CL_DOLLAR) ? K_BULK : K_ARRAY;
                    n_phase = PH_NUM_FIRST;
                end else begin
                    n_kind   = K_SIMPLE;
                    has_res  = 1'b1;
                    res_kind = K_SIMPLE;
                    res_err  = E_TYPE;
                end
            end
            PH_NUM: begin
                if (cls == CL_DIGIT) begin
                    if (n_num > (r_neg ? LIM_NEG : LIM_POS)) begin
                        has_res = 1'b1;
                        res_err = E_OVF;
                    end else begin
                        n_acc = n_num[31:0];
                    end
                end else if (cls == CL_CR) begin
                    n_phase = PH_NUM_LF;
                end else begin
                    has_res = 1'b1;
                    res_err = E_CRLF;
                end
            end
            PH_NUM_LF: begin
                has_res = 1'b1;
                n_phase = PH_TYPE;
                if (cls != CL_LF) begin
                    res_err = E_CRLF;
                end else if (r_kind == K_INT) begin
                    res_kind = K_INT;
                    res_val  = r_neg ? (32'd0 - mag) : mag;
                    res_done = 1'b1;
                end else if (r_neg && mag == 32'd1) begin
                    n_kind   = (r_kind == K_BULK) ? K_NULLBULK : K_NULLARRAY;
                    res_kind = n_kind;
                    res_val  = '1;
                    res_done = 1'b1;
                end else if (r_neg && mag > 32'd1) begin
                    res_err = E_NEG;
                end else if (r_kind == K_BULK) begin
                    n_bulk   = mag[30:0];
                    n_phase  = (mag != '0) ? PH_BULK : PH_BULK_CR;
                    res_kind = K_BULK;
                    res_val  = mag;
                end else if (mag == '0) begin
                    res_kind = K_ARRAY;
                    res_done = 1'b1;
                end else if (r_lvl >= LW'(MAX_DEPTH)) begin
                    res_err = E_DEEP;
                end else begin
                    res_kind = K_ARRAY;
                    res_val  = mag;
                    st_we    = 1'b1;
                    st_addr  = r_lvl[IW-1:0];
                    st_wdata = mag[30:0];
                    n_one[r_lvl[IW-1:0]] = (mag == 32'd1);
                    n_lvl    = r_lvl + LW'(1);
                end
            end
            PH_LINE: begin
                if (cls == CL_CR) begin
                    n_phase = PH_LINE_LF;
                end else begin
                    has_res  = 1'b1;
                    res_ev   = EV_DATA;
                    res_data = b;
                end
            end
            PH_LINE_LF: begin
                has_res = 1'b1;
                n_phase = PH_TYPE;
                if (cls != CL_LF) begin
                    res_err = E_CRLF;
                end else begin
                    res_ev   = EV_END;
                    res_done = 1'b1;
                end
            end
            PH_BULK: begin
                n_bulk   = r_bulk - 31'd1;
                if (n_bulk == '0) begin
                    n_phase = PH_BULK_CR;
                end
                has_res  = 1'b1;
                res_ev   = EV_DATA;
                res_kind = K_BULK;
                res_data = b;
            end
            PH_BULK_CR: begin
                if (cls != CL_CR) begin
                    has_res = 1'b1;
                    res_err = E_CRLF;
                end else begin
                    n_phase = PH_BULK_LF;
                end
            end
            PH_BULK_LF: begin
                has_res = 1'b1;
                n_phase = PH_TYPE;
                if (cls != CL_LF) begin
                    res_err = E_CRLF;
                end else begin
                    res_ev   = EV_END;
                    res_kind = K_BULK;
                    res_done = 1'b1;
                end
            end
            PH_TYPE + 4'd15: begin
                // Sign byte of a number line, already handled above.
            end
            default: begin
                n_phase = PH_TYPE;
            end
        endcase

        // res_done marks "an element ended"; resolve the nesting here.
        if (res_err != E_NONE) begin
            res_ev   = EV_ERR;
            res_val  = '0;
            res_done = 1'b0;
            n_phase  = PH_TYPE;
            n_lvl    = '0;
        end else if (res_done) begin
            if (r_lvl == '0 || !c_found) begin
                n_lvl = '0;
            end else begin
                res_done = 1'b0;
                st_we    = 1'b1;
                n_one[c_idx] = (c_cnt == 31'd2);
                n_lvl    = LW'(c_idx) + LW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_TYPE;
            r_kind   <= K_SIMPLE;
            r_acc    <= '0;
            r_neg    <= 1'b0;
            r_bulk   <= '0;
            r_lvl    <= '0;
            r_one    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (take && has_res) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            if (take) begin
                r_phase <= n_phase;
                r_kind  <= n_kind;
                r_acc   <= n_acc;
                r_neg   <= n_neg;
                r_bulk  <= n_bulk;
                r_lvl   <= n_lvl;
                r_one   <= n_one;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && st_we) begin
            r_stack[st_addr] <= st_wdata;
        end
        if (take && has_res) begin
            r_ev    <= res_ev;
            r_okind <= res_kind;
            r_val   <= res_val;
            r_data  <= res_data;
            r_depth <= 4'(r_lvl);
            r_done  <= res_done;
            r_err   <= res_err;
        end
    end

    assign o_out.valid        = r_ovalid;
    assign o_out.event_res    = r_ev;
    assign o_out.kind         = r_okind;
    assign o_out.value        = r_val;
    assign o_out.data_byte    = r_data;
    assign o_out.depth        = r_depth;
    assign o_out.message_done = r_done;
    assign o_out.error_code   = r_err;

    `RSP_ASSERT_NOW(a_lvl_bound, i_clk, i_rst_n, 1'b1, r_lvl <= LW'(MAX_DEPTH), "nesting overrun")
    `RSP_ASSERT_NOW(a_err_not_done, i_clk, i_rst_n, r_ovalid && r_ev == EV_ERR, !r_done && r_val == '0, "error word marks completion")
    `RSP_ASSERT_NEXT(a_err_resets, i_clk, i_rst_n, take && has_res && res_err != E_NONE, r_phase == PH_TYPE && r_lvl == '0, "error did not resync")
    `RSP_ASSERT_NEXT(a_done_top, i_clk, i_rst_n, take && has_res && res_done, r_lvl == '0, "message done inside an array")

endmodule

@@ hw/rtl/resp_stream_parser.sv @@
`timescale 1ns / 1ps
// Channel  Dir  Word                                           Handshake
// i_in     in   byte_in                                        valid/ready
// o_out    out  event_res kind value data_byte depth
//               message_done error_code                        valid/ready
//
// One byte per cycle sustained while the output is not stalled; each byte yields zero or one result word.
// A byte passes through the byte queue and then the output register.
// The parse state and the nesting stack update once per byte taken.
// Reset is synchronous, active low, and needs no clearing pass.
// Input and output stall independently; the byte queue absorbs two bytes.
module resp_stream_parser
    import rsp_pkg::*;
#(
    parameter int MAX_DEPTH = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rsp_in_if.sink i_in,
    rsp_out_if.source o_out
);

    logic  push, pop, full, empty;
    t_word in_word, q_word;

    rsp_front u_front (
        .i_in   (i_in),
        .i_full (full),
        .o_push (push),
        .o_word (in_word)
    );

    rsp_fifo #(
        .W     ($bits(t_word)),
        .DEPTH (2)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (in_word),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_data  (q_word)
    );

    rsp_back #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (!empty),
        .i_word  (q_word),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

@@ test/tb_resp_stream_parser.sv @@
`timescale 1ns / 1ps
module tb_resp_stream_parser;
    import rsp_pkg::*;

    localparam int DEPTH_LIMIT = 8;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [1:0]  ev;
        logic [2:0]  kind;
        logic [31:0] value;
        logic [7:0]  data;
        logic [3:0]  depth;
        logic        done;
        logic [2:0]  err;
    } t_result;

    class parse_scoreboard;
        logic [3:0]  phase;
        logic [2:0]  elem_kind;
        logic [31:0] accum;
        bit          negative;
        logic [30:0] bulk_left;
        logic [30:0] count_stack [DEPTH_LIMIT];
        int          level;
        t_result     pending [$];
        int          errors;
        int          results_seen;

        function new();
            phase = PH_TYPE;
            elem_kind = K_SIMPLE;
            accum = '0;
            negative = 0;
            bulk_left = '0;
            level = 0;
            errors = 0;
            results_seen = 0;
        endfunction

        function void emit(logic [1:0] ev, logic [2:0] k, logic [31:0] v,
                           logic [7:0] db, int d, bit dn, logic [2:0] e);
            t_result r;
            r.ev = ev; r.kind = k; r.value = v; r.data = db;
            r.depth = d[3:0]; r.done = dn; r.err = e;
            pending = {pending, r};
        endfunction

        function void raise_error(logic [2:0] code);
            int d;
            d = level;
            phase = PH_TYPE;
            level = 0;
            emit(EV_ERR, elem_kind, '0, '0, d, 0, code);
        endfunction

        // Pops every array that the ending element finishes.
        function bit close_element();
            logic [30:0] left;
            forever begin
                if (level == 0 || level > DEPTH_LIMIT) begin
                    level = 0;
                    return 1;
                end
                left = count_stack[level-1] - 31'd1;
                count_stack[level-1] = left;
                if (left != 0) return 0;
                level--;
            end
        endfunction

        function void end_number(int d);
            logic [31:0] mag;
            bit dn;
            mag = accum;
            phase = PH_TYPE;
            if (elem_kind == K_INT) begin
                dn = close_element();
                emit(EV_HEAD, K_INT, negative ? -mag : mag, '0, d, dn, E_NONE);
            end else if (negative && mag == 1) begin
                elem_kind = (elem_kind == K_BULK) ? K_NULLBULK : K_NULLARRAY;
                dn = close_element();
                emit(EV_HEAD, elem_kind, 32'hFFFF_FFFF, '0, d, dn, E_NONE);
            end else if (negative && mag > 1) begin
                raise_error(E_NEG);
            end else if (elem_kind == K_BULK) begin
                bulk_left = mag[30:0];
                phase = (mag != 0) ? PH_BULK : PH_BULK_CR;
                emit(EV_HEAD, K_BULK, mag, '0, d, 0, E_NONE);
            end else if (mag == 0) begin
                dn = close_element();
                emit(EV_HEAD, K_ARRAY, '0, '0, d, dn, E_NONE);
            end else if (level >= DEPTH_LIMIT) begin
                raise_error(E_DEEP);
            end else begin
                count_stack[level] = mag[30:0];
                level++;
                emit(EV_HEAD, K_ARRAY, mag, '0, d, 0, E_NONE);
            end
        endfunction

        function void note_byte(logic [7:0] b);
            int d;
            bit dn;
            logic [35:0] n;
            d = level;
            if (phase == PH_NUM_FIRST) begin
                phase = PH_NUM;
                if (b == CH_PLUS || b == CH_MINUS) begin
                    if (b == CH_PLUS && elem_kind != K_INT) raise_error(E_PLUS);
                    else negative = (b == CH_MINUS);
                    return;
                end
            end
            case (phase)
                PH_TYPE: begin
                    accum = '0;
                    negative = 0;
                    if (b == CH_PLUS || b == CH_MINUS) begin
                        elem_kind = (b == CH_PLUS) ? K_SIMPLE : K_ERROR;
                        phase = PH_LINE;
                        emit(EV_HEAD, elem_kind, '0, '0, d, 0, E_NONE);
                    end else if (b == CH_COLON || b == CH_DOLLAR || b == CH_STAR) begin
                        elem_kind = (b == CH_COLON) ? K_INT :
                                    (b == CH_DOLLAR) ? K_BULK : K_ARRAY;
                        phase = PH_NUM_FIRST;
                    end else begin
                        elem_kind = K_SIMPLE;
                        raise_error(E_TYPE);
                    end
                end
                PH_NUM: begin
                    if (b >= CH_ZERO && b <= CH_NINE) begin
                        n = {4'd0, accum} * 36'd10 + 36'(b - CH_ZERO);
                        if (n > (negative ? 36'h080000000 : 36'h07FFFFFFF))
                            raise_error(E_OVF);
                        else accum = n[31:0];
                    end else if (b == CH_CR) phase = PH_NUM_LF;
                    else raise_error(E_CRLF);
                end
                PH_NUM_LF: begin
                    if (b != CH_LF) raise_error(E_CRLF);
                    else end_number(d);
                end
                PH_LINE: begin
                    if (b == CH_CR) phase = PH_LINE_LF;
                    else emit(EV_DATA, elem_kind, '0, b, d, 0, E_NONE);
                end
                PH_LINE_LF: begin
                    if (b != CH_LF) raise_error(E_CRLF);
                    else begin
                        phase = PH_TYPE;
                        dn = close_element();
                        emit(EV_END, elem_kind, '0, '0, d, dn, E_NONE);
                    end
                end
                PH_BULK: begin
                    bulk_left = bulk_left - 31'd1;
                    if (bulk_left == 0) phase = PH_BULK_CR;
                    emit(EV_DATA, K_BULK, '0, b, d, 0, E_NONE);
                end
                PH_BULK_CR: begin
                    if (b != CH_CR) raise_error(E_CRLF);
                    else phase = PH_BULK_LF;
                end
                PH_BULK_LF: begin
                    if (b != CH_LF) raise_error(E_CRLF);
                    else begin
                        phase = PH_TYPE;
                        dn = close_element();
                        emit(EV_END, K_BULK, '0, '0, d, dn, E_NONE);
                    end
                end
                default: phase = PH_TYPE;
            endcase
        endfunction

        function void check_result(t_result act);
            t_result exp_r;
            results_seen++;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected word %h", $realtime, act);
                return;
            end
            exp_r = pending.pop_front();
            if (act !== exp_r) begin
                errors++;
                $display("%0t: expected ev=%0d kind=%0d value=%0d data=%h depth=%0d done=%0d err=%0d",
                         $realtime, exp_r.ev, exp_r.kind, $signed(exp_r.value), exp_r.data,
                         exp_r.depth, exp_r.done, exp_r.err);
                $display("%0t: actual   ev=%0d kind=%0d value=%0d data=%h depth=%0d done=%0d err=%0d",
                         $realtime, act.ev, act.kind, $signed(act.value), act.data,
                         act.depth, act.done, act.err);
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    rsp_in_if  in_ch ();
    rsp_out_if out_ch ();

    resp_stream_parser #(.MAX_DEPTH(DEPTH_LIMIT)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    always #10 i_clk = ~i_clk;

    parse_scoreboard board;
    logic [7:0] byte_stream [$];
    bit  calm;
    int  idle_cycles;
    int  bytes_sent;

    initial begin
        board = new();
    end

    // Sender: one byte per handshake, random gaps unless the run is calm.
    initial begin
        int gap;
        logic [7:0] b;
        in_ch.valid = 0;
        in_ch.byte_in = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        forever begin
            @(posedge i_clk);
            if (in_ch.valid && in_ch.ready) begin
                board.note_byte(in_ch.byte_in);
                bytes_sent++;
            end
            if (in_ch.valid && !in_ch.ready) continue;
            if (byte_stream.size() == 0) begin
                in_ch.valid <= 0;
                continue;
            end
            if (!calm && $urandom_range(0, 7) == 0) begin
                in_ch.valid <= 0;
                gap = $urandom_range(1, 10);
                repeat (gap - 1) @(posedge i_clk);
                continue;
            end
            b = byte_stream.pop_front();
            in_ch.valid <= 1;
            in_ch.byte_in <= b;
        end
    end

    // Receiver: checks every accepted word, stalls in random bursts.
    initial begin
        int stall;
        t_result r;
        out_ch.ready = 0;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) begin
                r = {out_ch.event_res, out_ch.kind, out_ch.value, out_ch.data_byte,
                     out_ch.depth, out_ch.message_done, out_ch.error_code};
                board.check_result(r);
            end
            if (i_rst_n && !calm && $urandom_range(0, 7) == 0) begin
                out_ch.ready <= 0;
                stall = $urandom_range(1, 10);
                repeat (stall - 1) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no traffic for %0d cycles", idle_cycles);
            $display("resp_stream_parser: mismatch");
            $finish;
        end
    end

    task automatic queue_byte(logic [7:0] b);
        byte_stream = {byte_stream, b};
    endtask

    task automatic put_text(string s);
        for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
    endtask

    task automatic put_number_line(logic [7:0] type_ch, longint n);
        queue_byte(type_ch);
        put_text($sformatf("%0d\r\n", n));
    endtask

    task automatic put_random_payload(int len, bit line);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            b = $urandom_range(0, 255);
            if (line && (b == CH_CR)) b = 8'hFF;
            queue_byte(b);
        end
    endtask

    // Builds one well-formed element at nesting level lvl; arrays at level nine or deeper are empty.
    task automatic put_element(int lvl);
        int pick;
        int cnt;
        pick = $urandom_range(0, 9);
        if (pick <= 1) begin
            queue_byte(pick ? CH_MINUS : CH_PLUS);
            put_random_payload($urandom_range(0, 5), 1);
            put_text("\r\n");
        end else if (pick <= 3) begin
            put_number_line(CH_COLON, $signed(32'($urandom())) >>> $urandom_range(0, 31));
        end else if (pick <= 6) begin
            cnt = $urandom_range(0, 6);
            if ($urandom_range(0, 9) == 0) put_text("$-1\r\n");
            else begin
                put_number_line(CH_DOLLAR, cnt);
                put_random_payload(cnt, 0);
                put_text("\r\n");
            end
        end else begin
            cnt = (lvl >= 9) ? 0 : $urandom_range(0, 3);
            if ($urandom_range(0, 11) == 0) put_text("*-1\r\n");
            else begin
                put_number_line(CH_STAR, cnt);
                for (int i = 0; i < cnt; i++) put_element(lvl + 1);
            end
        end
    endtask

    task automatic wait_drained();
        while (byte_stream.size() != 0 || in_ch.valid || board.pending.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    initial begin
        int n;
        @(posedge i_rst_n);
        // Directed: every type, extremes, null forms and each error.
        put_text("+OK\r\n-ERR x\r\n:2147483647\r\n:-2147483648\r\n:+5\r\n:\r\n");
        put_text("$0\r\n\r\n$-1\r\n$-0\r\n\r\n*-1\r\n*0\r\n*2\r\n:1\r\n$1\r\n\xff\r\n");
        put_text("*1\r\n*1\r\n*1\r\n*1\r\n*1\r\n*1\r\n*1\r\n*1\r\n*1\r\n");
        put_text("?$+3\r\n$-2\r\n:2147483648\r\n:-2147483649\r\n:1x\r\n+a\rb");
        put_text(":1\r\r$1\r\nab*1\r\n+x\r\n");
        queue_byte(8'h00);
        wait_drained();
        n = 0;
        while (bytes_sent < 950) begin
            if (bytes_sent > 800) calm = 1;
            if ($urandom_range(0, 9) == 0) begin
                put_random_payload($urandom_range(1, 4), 0);
                put_text("\r\n");
            end else begin
                put_element(0);
            end
            while (byte_stream.size() > 8) @(posedge i_clk);
            n++;
        end
        wait_drained();
        $display("Sent %0d bytes in %0d random messages; %0d result words checked.",
                 bytes_sent, n, board.results_seen);
        if (board.errors == 0)
            $display("resp_stream_parser: match");
        else
            $display("resp_stream_parser: mismatch");
        $finish;
    end
endmodule
